// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/mrc_pkg.sv =====
package mrc_pkg;

	// Frame limits.
	localparam int MAX_FRAME   = 256;
	localparam int HDR_DEPTH   = 6;
	localparam int CNT_W       = $clog2(MAX_FRAME + 1);
	localparam int HELD_W      = $clog2(HDR_DEPTH + 1);
	localparam int HIDX_W      = $clog2(HDR_DEPTH);
	localparam int FRAME_LEN_W = 9;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// CRC-16 as used on Modbus RTU links.
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// An exception reply sets the top bit of the function code.
	localparam logic [8:0] EXC_FLAG = 9'h080;

	// Function codes that get a closer look.
	localparam logic [7:0] FN_READ_COILS    = 8'd1;
	localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
	localparam logic [7:0] FN_WRITE_REGS    = 8'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SLAVE    = 3'd0,
		CFG_FUNCTION = 3'd1,
		CFG_ADDRESS  = 3'd2,
		CFG_QUANTITY = 3'd3,
		CFG_OVERHEAD = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TIMEOUT     = 3'd1,
		ST_BAD_CRC     = 3'd2,
		ST_WRONG_DEV   = 3'd3,
		ST_EXCEPTION   = 3'd4,
		ST_SIZE        = 3'd5,
		ST_UNSUPPORTED = 3'd6
	} status_t;

	// Request fields the reply is checked against.
	typedef struct packed {
		logic [7:0]  slave;
		logic [7:0]  func;
		logic [15:0] address;
		logic [15:0] quantity;
		logic [2:0]  overhead;
	} req_t;

	// Running state of the frame being received.
	typedef struct packed {
		logic [15:0]       crc;
		logic [CNT_W-1:0]  count;
		logic [HELD_W-1:0] held;
		logic              ovf;
	} frame_t;

	// First bytes of the reply, byte 0 in the lowest slot.
	typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

	// Fold one byte into the CRC, one bit per step.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/mrc_if.sv =====
// Reply byte channel.
interface mrc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       no_data;

	modport source (output valid, data_byte, last_byte, no_data, input ready);
	modport sink (input valid, data_byte, last_byte, no_data, output ready);
endinterface

// Frame verdict channel.
interface mrc_res_if import mrc_pkg::*;;
	logic                   valid;
	logic                   ready;
	status_t                status;
	logic [FRAME_LEN_W-1:0] frame_length;

	modport source (output valid, status, frame_length, input ready);
	modport sink (input valid, status, frame_length, output ready);
endinterface

// Register write channel.
interface mrc_cfg_if import mrc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mrc_judge.sv =====
module mrc_judge import mrc_pkg::*; (
	input  frame_t  fr,
	input  hdr_t    hdr,
	input  req_t    req,
	output status_t status
);

	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	logic [7:0]       fn;
	logic             is_read;
	logic             is_write;
	logic             exc_match;
	logic [CNT_W-1:0] cnt_net;
	logic             cnt_ok;
	logic             echo_ok;

	assign fn = hdr[1];

	assign is_read  = (fn == FN_READ_COILS) || (fn == FN_READ_DISCRETE) ||
	                  (fn == FN_READ_HOLDING);
	assign is_write = (fn == FN_WRITE_COIL) || (fn == FN_WRITE_COILS) ||
	                  (fn == FN_WRITE_REGS);

	// The exception code is compared without wrap past 0xFF.
	assign exc_match = ({1'b0, fn} == ({1'b0, req.func} + EXC_FLAG));

	// Byte count of a read reply: frame length less the framing overhead.
	assign cnt_net = fr.count - CNT_W'(req.overhead);
	assign cnt_ok  = (fr.count >= CNT_W'(req.overhead)) && (fr.held > HELD_W'(2)) &&
	                 (CMP_W'(cnt_net) == CMP_W'(hdr[2]));

	// Write replies echo the address and quantity of the request.
	assign echo_ok = (fr.held >= HELD_W'(HDR_DEPTH)) &&
	                 (hdr[2] == req.address[15:8])  && (hdr[3] == req.address[7:0]) &&
	                 (hdr[4] == req.quantity[15:8]) && (hdr[5] == req.quantity[7:0]);

	// Checks in priority order.
	always_comb begin
		priority if (fr.count == '0) begin
			status = ST_TIMEOUT;
		end else if (fr.ovf) begin
			status = ST_SIZE;
		end else if (fr.crc != 16'h0000) begin
			status = ST_BAD_CRC;
		end else if (hdr[0] != req.slave || fr.held < HELD_W'(2)) begin
			status = ST_WRONG_DEV;
		end else if (fn != req.func) begin
			status = exc_match ? ST_EXCEPTION : ST_WRONG_DEV;
		end else if (is_read) begin
			status = cnt_ok ? ST_OK : ST_SIZE;
		end else if (is_write) begin
			status = echo_ok ? ST_OK : ST_SIZE;
		end else begin
			status = ST_UNSUPPORTED;
		end
	end

endmodule

// ===== rtl/modbus_response_checker.sv =====
// Timing: a word is judged in the cycle after its acceptance; a frame-ending word
// has its verdict registered in the result register once it leaves the input stage.
// Throughput: one reply word per cycle, set by the combinational CRC byte update; a
// frame-ending word waits only while an earlier verdict is still unaccepted.
// Reset: asynchronous, active low; clears the request registers (overhead to 5),
// the running CRC, byte count and the pipeline valids.
`include "assert_macros.svh"

module modbus_response_checker import mrc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	mrc_rx_if.sink    rx,
	mrc_res_if.source res,
	mrc_cfg_if.sink   cfg
);

	req_t                   req_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   none_s1;
	frame_t                 frame_q;
	hdr_t                   hdr_q;
	frame_t                 frame_upd;
	hdr_t                   hdr_upd;
	logic                   end_s1;
	logic                   adv_s1;
	logic                   take_s1;
	logic                   store_s1;
	logic                   hdr_wr;
	status_t                judge_status;
	logic                   res_valid_q;
	status_t                res_status_q;
	logic [FRAME_LEN_W-1:0] res_len_q;

	// Register writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '{slave: 8'h00, func: 8'h00, address: 16'h0000,
			           quantity: 16'h0000, overhead: 3'd5};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SLAVE:    req_q.slave    <= cfg.data[7:0];
				CFG_FUNCTION: req_q.func     <= cfg.data[7:0];
				CFG_ADDRESS:  req_q.address  <= cfg.data;
				CFG_QUANTITY: req_q.quantity <= cfg.data;
				CFG_OVERHEAD: req_q.overhead <= cfg.data[2:0];
				default: ;
			endcase
		end
	end

	// Input stage. Only a frame-ending word can wait on a full result register.
	assign end_s1   = none_s1 || last_s1;
	assign adv_s1   = valid_s1 && (!end_s1 || !res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
			last_s1 <= rx.last_byte;
			none_s1 <= rx.no_data;
		end
	end

	// Fold the word into the frame state; bytes past the limit only flag overflow.
	assign take_s1  = valid_s1 && !none_s1;
	assign store_s1 = take_s1 && (frame_q.count < CNT_W'(MAX_FRAME));
	assign hdr_wr   = store_s1 && (frame_q.held < HELD_W'(HDR_DEPTH));

	always_comb begin
		frame_upd = frame_q;
		hdr_upd   = hdr_q;
		if (take_s1 && !store_s1) begin
			frame_upd.ovf = 1'b1;
		end
		if (store_s1) begin
			frame_upd.crc   = crc_byte(frame_q.crc, byte_s1);
			frame_upd.count = frame_q.count + CNT_W'(1);
		end
		if (hdr_wr) begin
			frame_upd.held = frame_q.held + HELD_W'(1);
			hdr_upd[frame_q.held[HIDX_W-1:0]] = byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '{crc: CRC_INIT, count: '0, held: '0, ovf: 1'b0};
		end else if (adv_s1) begin
			if (end_s1) begin
				frame_q <= '{crc: CRC_INIT, count: '0, held: '0, ovf: 1'b0};
			end else begin
				frame_q <= frame_upd;
			end
		end
	end

	// Header bytes are guarded by the held count and need no reset.
	always_ff @(posedge clk) begin
		if (adv_s1 && hdr_wr) begin
			hdr_q <= hdr_upd;
		end
	end

	mrc_judge u_judge (
		.fr     (frame_upd),
		.hdr    (hdr_upd),
		.req    (req_q),
		.status (judge_status)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && end_s1) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && end_s1) begin
			res_status_q <= judge_status;
			res_len_q    <= FRAME_LEN_W'(frame_upd.count);
		end
	end

	assign res.valid        = res_valid_q;
	assign res.status       = res_status_q;
	assign res.frame_length = res_len_q;

	// Frame state is back at its idle value after every frame end.
	`ASSERT_PROP(a_frame_cleared, clk, arst_n,
		(adv_s1 && end_s1) |=> (frame_q.count == '0 && frame_q.held == '0 &&
			!frame_q.ovf && frame_q.crc == CRC_INIT))

	// The header count tracks the byte count up to the header depth.
	`ASSERT_PROP(a_held_tracks, clk, arst_n,
		frame_q.held == ((frame_q.count >= CNT_W'(HDR_DEPTH)) ?
			HELD_W'(HDR_DEPTH) : HELD_W'(frame_q.count)))

	// A timeout verdict goes with an empty frame and only with one.
	`ASSERT_PROP(a_timeout_empty, clk, arst_n,
		res_valid_q |-> ((res_status_q == ST_TIMEOUT) == (res_len_q == '0)))

	// A result still waiting holds off the next frame end.
	`ASSERT_PROP(a_no_overwrite, clk, arst_n,
		(res_valid_q && !res.ready && valid_s1 && end_s1) |-> !adv_s1)

endmodule

// ===== tb/sv/modbus_response_checker_tb.sv =====
`timescale 1ns / 100ps

module modbus_response_checker_tb import mrc_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;

	// One word on the reply byte channel.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       no_data;
	} rx_word_t;

	// What the block should say about one frame.
	typedef struct {
		status_t                status;
		logic [FRAME_LEN_W-1:0] frame_length;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mrc_rx_if  rx ();
	mrc_res_if res ();
	mrc_cfg_if cfg ();

	modbus_response_checker DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx),
		.res   (res),
		.cfg   (cfg)
	);

	// Request the reply is judged against, as last written to the block.
	req_t request;

	// Running state of the frame being received.
	logic [15:0]            rx_crc = 16'hFFFF;
	logic [FRAME_LEN_W-1:0] rx_count = '0;
	logic [7:0]             hdr_seen [HDR_DEPTH];
	int                     hdr_held = 0;
	logic                   rx_overflow = 1'b0;

	rx_word_t   words_pending [$];
	verdict_t   verdicts_due [$];
	logic [7:0] frame_bytes [$];
	int         words_queued = 0;
	rx_word_t   next_word;

	int   mismatches = 0;
	int   cycle_count = 0;
	int   src_wait = 0;
	int   sink_wait = 0;
	bit   src_steady = 1'b0;
	bit   sink_steady = 1'b0;
	bit   hold_wanted = 1'b0;
	logic hold_res = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Modbus CRC-16, fed one bit at a time, least significant bit first.
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = {1'b0, c[15:1]};
			if (fb) c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	// True when header byte i arrived and equals v.
	function automatic bit hdr_has(input int i, input int v);
		return i < hdr_held && int'(hdr_seen[i]) == v;
	endfunction

	// Verdict for the frame that just ended, in priority order.
	function automatic status_t judge_reply();
		logic [7:0] fn;
		if (rx_count == '0) return ST_TIMEOUT;
		if (rx_overflow) return ST_SIZE;
		if (rx_crc != 16'h0000) return ST_BAD_CRC;
		if (!hdr_has(0, int'(request.slave)) || hdr_held < 2) return ST_WRONG_DEV;
		fn = hdr_seen[1];
		if (fn != request.func) begin
			// The exception code is the function plus the flag, with no wrap.
			if ({1'b0, fn} == {1'b0, request.func} + EXC_FLAG) return ST_EXCEPTION;
			return ST_WRONG_DEV;
		end
		case (fn)
			FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING: begin
				if (int'(rx_count) < int'(request.overhead)) return ST_SIZE;
				return hdr_has(2, int'(rx_count) - int'(request.overhead)) ? ST_OK : ST_SIZE;
			end
			FN_WRITE_COIL, FN_WRITE_COILS, FN_WRITE_REGS: begin
				if (hdr_has(2, int'(request.address[15:8])) &&
				    hdr_has(3, int'(request.address[7:0])) &&
				    hdr_has(4, int'(request.quantity[15:8])) &&
				    hdr_has(5, int'(request.quantity[7:0])))
					return ST_OK;
				return ST_SIZE;
			end
			default: return ST_UNSUPPORTED;
		endcase
	endfunction

	// Fold one accepted word into the frame state; a frame end yields a verdict.
	task automatic track_word(input logic [7:0] b, input logic last, input logic none);
		verdict_t v;
		if (!none) begin
			if (int'(rx_count) >= MAX_FRAME) begin
				rx_overflow = 1'b1;
			end else begin
				rx_crc = crc16_step(rx_crc, b);
				if (hdr_held < HDR_DEPTH) begin
					hdr_seen[hdr_held] = b;
					hdr_held++;
				end
				rx_count++;
			end
		end
		if (none || last) begin
			v.status = judge_reply();
			v.frame_length = rx_count;
			verdicts_due.push_back(v);
			rx_crc = CRC_INIT;
			rx_count = '0;
			hdr_held = 0;
			rx_overflow = 1'b0;
		end
	endtask

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic check_verdict(input status_t st, input logic [FRAME_LEN_W-1:0] len);
		verdict_t v;
		if (verdicts_due.size() == 0) begin
			flag_mismatch($sformatf("verdict with none due: status %0d length %0d", st, len));
		end else begin
			v = verdicts_due.pop_front();
			if (st !== v.status)
				flag_mismatch($sformatf("status %0d, want %0d", st, v.status));
			if (len !== v.frame_length)
				flag_mismatch($sformatf("frame_length %0d, want %0d", len, v.frame_length));
		end
	endtask

	function automatic int draw_pause(input bit steady);
		if (steady || $urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 13);
	endfunction

	// Reply byte driver: one word at a time, with a random pause after each.
	always @(posedge clk) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
			src_wait = 0;
		end else if (!rx.valid || rx.ready) begin
			if (rx.valid) track_word(rx.data_byte, rx.last_byte, rx.no_data);
			if (src_wait > 0) begin
				src_wait--;
				rx.valid <= 1'b0;
			end else if (words_pending.size() != 0) begin
				next_word = words_pending.pop_front();
				rx.data_byte <= next_word.data_byte;
				rx.last_byte <= next_word.last_byte;
				rx.no_data <= next_word.no_data;
				rx.valid <= 1'b1;
				src_wait = draw_pause(src_steady);
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// Verdict monitor: checks each accepted verdict and stalls at random afterwards.
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (res.valid && res.ready) begin
				check_verdict(res.status, res.frame_length);
				sink_wait = draw_pause(sink_steady);
			end
			if (sink_wait > 0) begin
				sink_wait--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= !hold_res;
			end
		end
	end

	// One long hold on the verdict side so that the block backs up into its input.
	initial begin
		wait (hold_wanted);
		@(posedge clk);
		hold_res <= 1'b1;
		repeat (300) @(posedge clk);
		hold_res <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL modbus_response_checker");
			$finish;
		end
	end

	// Register writes leave valid high between back-to-back words.
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (cfg.ready !== 1'b1);
	endtask

	// Unused upper data bits carry junk; the block must ignore them.
	task automatic load_request(input req_t r);
		logic [7:0] junk;
		junk = 8'($urandom_range(0, 255));
		write_reg(CFG_SLAVE, {junk, r.slave});
		write_reg(CFG_FUNCTION, {~junk, r.func});
		write_reg(CFG_ADDRESS, r.address);
		write_reg(CFG_QUANTITY, r.quantity);
		write_reg(CFG_OVERHEAD, {junk, junk[4:0], r.overhead});
		cfg.valid <= 1'b0;
		request = r;
	endtask

	function automatic req_t make_request(input logic [7:0] slave, input logic [7:0] func,
	                                      input logic [15:0] address,
	                                      input logic [15:0] quantity,
	                                      input logic [2:0] overhead);
		req_t r;
		r.slave = slave;
		r.func = func;
		r.address = address;
		r.quantity = quantity;
		r.overhead = overhead;
		return r;
	endfunction

	function automatic logic [15:0] pick_wide();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly read and write functions, plus the odd and edge codes.
	function automatic req_t pick_request();
		req_t r;
		case ($urandom_range(0, 3))
			0: r.slave = 8'h00;
			1: r.slave = 8'hFF;
			default: r.slave = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 11))
			0: r.func = FN_READ_COILS;
			1: r.func = FN_READ_DISCRETE;
			2: r.func = FN_READ_HOLDING;
			3: r.func = FN_WRITE_COIL;
			4: r.func = FN_WRITE_COILS;
			5: r.func = FN_WRITE_REGS;
			6: r.func = 8'h00;
			7: r.func = 8'hFF;
			8: r.func = 8'h7F;
			9: r.func = 8'h80;
			default: r.func = 8'($urandom_range(0, 255));
		endcase
		r.address = pick_wide();
		r.quantity = pick_wide();
		r.overhead = 3'($urandom_range(0, 7));
		return r;
	endfunction

	// Unsealed reply body that fits the current request.
	task automatic build_reply(input int payload);
		logic [7:0] byte_count;
		byte_count = 8'(payload + 5 - int'(request.overhead));
		frame_bytes.delete();
		frame_bytes.push_back(request.slave);
		frame_bytes.push_back(request.func);
		case (request.func)
			FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING: begin
				frame_bytes.push_back(byte_count);
				repeat (payload) frame_bytes.push_back(8'($urandom_range(0, 255)));
			end
			FN_WRITE_COIL, FN_WRITE_COILS, FN_WRITE_REGS: begin
				frame_bytes.push_back(request.address[15:8]);
				frame_bytes.push_back(request.address[7:0]);
				frame_bytes.push_back(request.quantity[15:8]);
				frame_bytes.push_back(request.quantity[7:0]);
			end
			default: repeat (payload) frame_bytes.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic build_exception();
		logic [7:0] fn;
		fn = request.func + EXC_FLAG[7:0];
		frame_bytes.delete();
		frame_bytes.push_back(request.slave);
		frame_bytes.push_back(fn);
		frame_bytes.push_back(8'($urandom_range(1, 11)));
	endtask

	// Append the CRC, low byte first, so the whole frame folds to zero.
	task automatic seal_frame();
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_bytes[i]) c = crc16_step(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endtask

	task automatic queue_timeout();
		rx_word_t w;
		w.data_byte = 8'($urandom_range(0, 255));
		w.last_byte = 1'($urandom_range(0, 1));
		w.no_data = 1'b1;
		words_pending.push_back(w);
		words_queued++;
	endtask

	// A silent close ends the frame with a no-data word instead of the last flag.
	task automatic send_frame(input bit silent);
		rx_word_t w;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			w.data_byte = frame_bytes[i];
			w.last_byte = !silent && (i == frame_bytes.size() - 1);
			w.no_data = 1'b0;
			words_pending.push_back(w);
			words_queued++;
		end
		if (silent || frame_bytes.size() == 0) queue_timeout();
	endtask

	task automatic flip_one_bit();
		logic [7:0] flip;
		flip = 8'h01 << $urandom_range(0, 7);
		frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^= flip;
	endtask

	task automatic random_traffic(input int budget);
		int         goal;
		int         pick;
		int         keep;
		logic [7:0] mask;
		goal = words_queued + budget;
		while (words_queued < goal) begin
			pick = $urandom_range(0, 99);
			mask = 8'($urandom_range(1, 255));
			if (pick < 8) begin
				queue_timeout();
			end else if (pick >= 94) begin
				// Random bytes, sealed half the time.
				frame_bytes.delete();
				repeat ($urandom_range(1, 10))
					frame_bytes.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 1)) seal_frame();
				send_frame($urandom_range(0, 5) == 0);
			end else begin
				if (pick < 16) build_exception();
				else build_reply($urandom_range(0, 6));
				if (pick >= 16 && pick < 24) begin
					frame_bytes[$urandom_range(0, 1)] ^= mask;
				end else if (pick >= 24 && pick < 32) begin
					keep = $urandom_range(0, frame_bytes.size() - 1);
					while (frame_bytes.size() > keep) frame_bytes.delete(frame_bytes.size() - 1);
				end else if (pick >= 32 && pick < 38 && frame_bytes.size() > 2) begin
					frame_bytes[2] += mask;
				end
				seal_frame();
				if (pick >= 38 && pick < 46) flip_one_bit();
				send_frame($urandom_range(0, 5) == 0);
			end
		end
	endtask

	// A frame one byte past the length limit, closed by a no-data word.
	task automatic long_frames();
		build_reply(2);
		while (frame_bytes.size() < MAX_FRAME + 1)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		send_frame(1'b1);
	endtask

	// Wait until every word is taken and every verdict is in, then let the block settle.
	task automatic drain();
		while (words_pending.size() != 0 || rx.valid || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		rx.valid = 1'b0;
		rx.data_byte = 8'h00;
		rx.last_byte = 1'b0;
		rx.no_data = 1'b0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_SLAVE;
		cfg.data = '0;
		request = make_request(8'h00, 8'h00, 16'h0000, 16'h0000, 3'd5);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: a timeout, then a matching reply to function zero.
		queue_timeout();
		frame_bytes = '{8'h00, 8'h00, 8'hAA};
		seal_frame();
		send_frame(1'b0);
		drain();

		// Holding register read: good, silent close, bad count, bad CRC,
		// wrong slave, exception, wrong function and a lone byte.
		load_request(make_request(8'h11, FN_READ_HOLDING, 16'h006B, 16'h0003, 3'd5));
		build_reply(2);
		seal_frame();
		send_frame(1'b0);
		build_reply(0);
		seal_frame();
		send_frame(1'b1);
		build_reply(1);
		frame_bytes[2] ^= 8'h01;
		seal_frame();
		send_frame(1'b0);
		build_reply(1);
		seal_frame();
		flip_one_bit();
		send_frame(1'b0);
		build_reply(1);
		frame_bytes[0] = 8'h12;
		seal_frame();
		send_frame(1'b0);
		build_exception();
		seal_frame();
		send_frame(1'b0);
		build_reply(1);
		frame_bytes[1] = 8'h04;
		seal_frame();
		send_frame(1'b0);
		frame_bytes = '{8'h11};
		send_frame(1'b0);
		drain();

		// Register write at the extremes: good echo, bad echo, short echo, exception.
		load_request(make_request(8'hFF, FN_WRITE_REGS, 16'hFFFF, 16'hFFFF, 3'd0));
		build_reply(0);
		seal_frame();
		send_frame(1'b0);
		build_reply(0);
		frame_bytes[5] ^= 8'h80;
		seal_frame();
		send_frame(1'b0);
		build_reply(0);
		frame_bytes.delete(5);
		frame_bytes.delete(4);
		seal_frame();
		send_frame(1'b1);
		build_exception();
		seal_frame();
		send_frame(1'b0);
		drain();

		// Function 0x80 can never see a matching exception code.
		load_request(make_request(8'h00, 8'h80, 16'h0000, 16'h0000, 3'd7));
		build_reply(1);
		seal_frame();
		send_frame(1'b0);
		frame_bytes = '{8'h00, 8'h00};
		seal_frame();
		send_frame(1'b0);
		drain();

		// Large overhead: a frame shorter than the overhead, then an exact fit.
		load_request(make_request(8'h01, FN_READ_COILS, 16'h1234, 16'h0001, 3'd7));
		frame_bytes = '{8'h01, 8'h01};
		seal_frame();
		send_frame(1'b0);
		build_reply(2);
		seal_frame();
		send_frame(1'b0);
		drain();

		// Highest function whose exception code still fits in a byte.
		load_request(make_request(8'h5A, 8'h7F, 16'h0000, 16'hFFFF, 3'd0));
		build_exception();
		seal_frame();
		send_frame(1'b0);
		drain();

		for (int p = 0; p < 7; p++) begin
			load_request(pick_request());
			src_steady = (p == 2 || p == 5);
			sink_steady = (p == 2 || p == 4);
			random_traffic(40);
			if (p == 3) long_frames();
			drain();
		end

		// Short frames at full rate while the verdict side holds off.
		load_request(make_request(8'h2C, FN_READ_DISCRETE, 16'h0000, 16'h0000, 3'd5));
		src_steady = 1'b1;
		sink_steady = 1'b0;
		repeat (24) begin
			if ($urandom_range(0, 2) == 0) begin
				queue_timeout();
			end else begin
				build_reply(0);
				seal_frame();
				send_frame(1'b0);
			end
		end
		hold_wanted = 1'b1;
		drain();

		if (mismatches == 0)
			$display("PASS modbus_response_checker");
		else
			$display("FAIL modbus_response_checker");
		$finish;
	end

endmodule
